### src/jtn_pkg.sv
// shared types, command codes and tap path table for the tms path generator
package jtn_pkg;

	// command codes
	localparam logic [1:0] CMD_GOTO  = 2'd0;
	localparam logic [1:0] CMD_RESET = 2'd1;
	localparam logic [1:0] CMD_IDLE  = 2'd2;

	// number of tms high clocks for a reset command
	localparam logic [5:0] RESET_CLOCKS = 6'd5;

	// all-ones pattern loaded for a reset command
	localparam logic [7:0] RESET_BITS = 8'hff;

	// tap states
	localparam logic [3:0] TAP_TLR = 4'd0;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic step;
	} jtn_ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic rem_zero;
		logic slot_free;
	} jtn_status_t;

	// one precomputed shortest path: length and tms bits, first bit in bit 0
	typedef struct packed {
		logic [3:0] len;
		logic [7:0] bits;
	} path_ent_t;

	typedef path_ent_t [255:0] path_tbl_t;

	// ieee 1149.1 tap transition
	function automatic logic [3:0] tap_next(input logic [3:0] s, input logic tms);
		logic [3:0] ns;
		unique case (s)
			4'd0:  ns = tms ? 4'd0  : 4'd1;
			4'd1:  ns = tms ? 4'd2  : 4'd1;
			4'd2:  ns = tms ? 4'd9  : 4'd3;
			4'd3:  ns = tms ? 4'd5  : 4'd4;
			4'd4:  ns = tms ? 4'd5  : 4'd4;
			4'd5:  ns = tms ? 4'd8  : 4'd6;
			4'd6:  ns = tms ? 4'd7  : 4'd6;
			4'd7:  ns = tms ? 4'd8  : 4'd4;
			4'd8:  ns = tms ? 4'd2  : 4'd1;
			4'd9:  ns = tms ? 4'd0  : 4'd10;
			4'd10: ns = tms ? 4'd12 : 4'd11;
			4'd11: ns = tms ? 4'd12 : 4'd11;
			4'd12: ns = tms ? 4'd15 : 4'd13;
			4'd13: ns = tms ? 4'd14 : 4'd13;
			4'd14: ns = tms ? 4'd15 : 4'd11;
			4'd15: ns = tms ? 4'd2  : 4'd1;
			default: ns = TAP_TLR;
		endcase
		return ns;
	endfunction

	// breadth-first search per start and goal, tms low tried first,
	// first predecessor kept; evaluated at elaboration only
	function automatic path_tbl_t build_path_tbl();
		path_tbl_t tbl;
		logic [15:0][3:0] fifo;
		logic [15:0][3:0] from;
		logic [15:0] seen;
		logic [15:0] via;
		logic [15:0] pathv;
		logic [7:0] bits;
		logic [3:0] ns;
		int rd;
		int wr;
		int len;
		int s;
		int cur;
		for (int st = 0; st < 16; st++) begin
			for (int g = 0; g < 16; g++) begin
				seen = '0;
				via = '0;
				from = '0;
				fifo = '0;
				pathv = '0;
				bits = '0;
				len = 0;
				rd = 0;
				wr = 0;
				if (st != g) begin
					seen[st] = 1'b1;
					fifo[wr] = st[3:0];
					wr++;
					while (rd < wr && !seen[g]) begin
						s = int'(fifo[rd]);
						rd++;
						for (int t = 0; t < 2; t++) begin
							ns = tap_next(s[3:0], t[0]);
							if (!seen[ns] && wr < 16) begin
								seen[ns] = 1'b1;
								from[ns] = s[3:0];
								via[ns] = t[0];
								fifo[wr] = ns;
								wr++;
							end
						end
					end
					cur = g;
					while (cur != st && len < 8) begin
						pathv[len] = via[cur];
						len++;
						cur = int'(from[cur]);
					end
					for (int k = 0; k < len; k++)
						bits[k] = pathv[len - 1 - k];
				end
				tbl[st * 16 + g].len = len[3:0];
				tbl[st * 16 + g].bits = bits;
			end
		end
		return tbl;
	endfunction

	// shortest tms path from tracked state (upper index) to goal (lower index)
	localparam path_tbl_t PATH_TBL = build_path_tbl();

endpackage

### src/jtn_ctrl.sv
// controller state machine for the tms path generator
module jtn_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  jtn_pkg::jtn_status_t status,
	output jtn_pkg::jtn_ctl_t    ctl
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;
	logic state_nxt;

	// idle takes a command, run shifts out its tms bits
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_nxt = ST_RUN;
			end
			ST_RUN: begin
				if (status.rem_zero)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

	// commands to the datapath
	assign in_stall = (state_q != ST_IDLE);
	assign ctl.load = in_valid && (state_q == ST_IDLE);
	assign ctl.step = (state_q == ST_RUN) && !status.rem_zero && status.slot_free;

endmodule

### src/jtn_datapath.sv
// tap state tracker, tms shifter and output register
module jtn_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  jtn_pkg::jtn_ctl_t    ctl,
	output jtn_pkg::jtn_status_t status,
	input  logic [1:0]           cmd,
	input  logic [3:0]           target_state,
	input  logic [5:0]           idle_count,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 tms_bit,
	output logic [3:0]           tap_state_after,
	output logic                 last_bit
);

	logic [3:0] tap_q;
	logic [7:0] bits_q;
	logic [5:0] rem_q;
	logic       out_valid_q;
	logic       tms_q;
	logic [3:0] state_out_q;
	logic       last_q;

	jtn_pkg::path_ent_t path;
	logic [7:0] load_bits;
	logic [5:0] load_rem;
	logic [3:0] tap_nxt;

	// per-command bit pattern and length
	always_comb begin
		path = jtn_pkg::PATH_TBL[{tap_q, target_state}];
		load_bits = '0;
		load_rem = '0;
		unique case (cmd)
			jtn_pkg::CMD_GOTO: begin
				load_bits = path.bits;
				load_rem = {2'b00, path.len};
			end
			jtn_pkg::CMD_RESET: begin
				load_bits = jtn_pkg::RESET_BITS;
				load_rem = jtn_pkg::RESET_CLOCKS;
			end
			jtn_pkg::CMD_IDLE: begin
				load_bits = '0;
				load_rem = idle_count;
			end
			default: begin
				load_bits = '0;
				load_rem = '0;
			end
		endcase
	end

	assign tap_nxt = jtn_pkg::tap_next(tap_q, bits_q[0]);

	// tracked state and remaining bit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= jtn_pkg::TAP_TLR;
			rem_q <= '0;
		end else if (ctl.load) begin
			rem_q <= load_rem;
		end else if (ctl.step) begin
			tap_q <= tap_nxt;
			rem_q <= rem_q - 6'd1;
		end
	end

	// tms bit shifter, first bit in bit 0
	always_ff @(posedge clk) begin
		if (ctl.load)
			bits_q <= load_bits;
		else if (ctl.step)
			bits_q <= {1'b0, bits_q[7:1]};
	end

	// output item valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.step)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	// output item payload
	always_ff @(posedge clk) begin
		if (ctl.step) begin
			tms_q <= bits_q[0];
			state_out_q <= tap_nxt;
			last_q <= (rem_q == 6'd1);
		end
	end

	assign status.rem_zero = (rem_q == 6'd0);
	assign status.slot_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign tms_bit = tms_q;
	assign tap_state_after = state_out_q;
	assign last_bit = last_q;

endmodule

### src/jtag_tap_tms_path_generator.sv
// top level of the jtag tap tms path generator
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_stall  | cmd, target_state, idle_count
//  output  | out_valid / out_stall| tms_bit, tap_state_after, last_bit
//
// each accepted command yields n output items, n being its tms bit count: at most
// 8 for goto, 5 for reset, idle_count for idle; the first tms bit moves from the
// loaded shifter into the output register, then the shifter gives one output item
// per cycle while out_stall is low.
// arst_n clears the tracked tap state to test-logic-reset and drops out_valid.
// in_stall stays high while a command is still shifting out and until run ends;
// out_stall holds the output register and, with out_valid high, pauses the shifter.
module jtag_tap_tms_path_generator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [3:0] target_state,
	input  logic [5:0] idle_count,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       tms_bit,
	output logic [3:0] tap_state_after,
	output logic       last_bit
);

	jtn_pkg::jtn_ctl_t    ctl;
	jtn_pkg::jtn_status_t status;

	// command sequencing
	jtn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.ctl      (ctl)
	);

	// state tracking and tms generation
	jtn_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.status          (status),
		.cmd             (cmd),
		.target_state    (target_state),
		.idle_count      (idle_count),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.tms_bit         (tms_bit),
		.tap_state_after (tap_state_after),
		.last_bit        (last_bit)
	);

endmodule
